>>> design/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the stereo linear resampler with output ring.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int RING_FRAMES_DEF   = 8192;
    localparam int FRACTION_BITS_DEF = 6;
    localparam int STEP_W            = 12;
    localparam int SAMPLE_W          = 16;
    localparam int FILL_W            = 14;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [STEP_W-1:0] STEP_RESET = 12'd375;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       underrun;
        logic        [FILL_W-1:0]   fill_frames;
    } rsp_t;

    // command passed from the front to the back: a frame to store or a pop
    typedef struct packed {
        logic                is_pop;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } cmd_t;

endpackage

`default_nettype wire

>>> design/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front
// Accepts items, keeps phase and previous frame, interpolates pushes and
// issues store or pop commands.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_front #(
    parameter int FRACTION_BITS = srr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srr_pkg::STEP_W-1:0]      cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire srr_pkg::req_t                   req,
    output logic                                 enq_valid,
    input  wire logic                            enq_ready,
    output srr_pkg::cmd_t                        enq_cmd
);

    localparam int F    = FRACTION_BITS;
    localparam int PH_W = ((F > srr_pkg::STEP_W) ? F : srr_pkg::STEP_W) + 1;
    localparam int NUM_W = F + 19;
    localparam logic [PH_W-1:0] ONE_Q = PH_W'(1) << F;

    logic [srr_pkg::STEP_W-1:0]   step_reg;
    logic [PH_W-1:0]              phase_reg, phase_next;
    logic [srr_pkg::SAMPLE_W-1:0] prev_l_reg, prev_r_reg;
    logic [PH_W-1:0]              ph_add;
    logic                         emit;
    logic                         accept;

    function automatic logic [15:0] interp(input logic signed [15:0] p,
                                           input logic signed [15:0] c,
                                           input logic [F-1:0] ph);
        logic signed [16:0]      diff;
        logic signed [F:0]       ph_s;
        logic signed [F+17:0]    prod;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] num_b;
        logic signed [NUM_W-1:0] q;
        diff  = {c[15], c} - {p[15], p};
        ph_s  = {1'b0, ph};
        prod  = diff * ph_s;
        num   = $signed({{3{p[15]}}, p, {F{1'b0}}}) + $signed({prod[F+17], prod});
        // bias negatives so the shift truncates toward zero
        num_b = num + (num[NUM_W-1] ? $signed(NUM_W'((1 << F) - 1)) : $signed(NUM_W'(0)));
        q     = num_b >>> F;
        return q[15:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign req_ready = enq_ready;
    assign accept    = req_valid && req_ready;
    assign emit      = (phase_reg < ONE_Q);

    always_comb
    begin
        ph_add     = emit ? (phase_reg + PH_W'(step_reg)) : phase_reg;
        phase_next = (ph_add >= ONE_Q) ? (ph_add - ONE_Q) : '0;
    end

    always_comb
    begin
        enq_cmd.is_pop = (req.operation == srr_pkg::OP_POP);
        enq_cmd.left   = interp(prev_l_reg, req.left_sample, phase_reg[F-1:0]);
        enq_cmd.right  = interp(prev_r_reg, req.right_sample, phase_reg[F-1:0]);
        enq_valid      = req_valid && ((req.operation == srr_pkg::OP_POP) || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= srr_pkg::STEP_RESET;
            phase_reg  <= '0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_reg <= cfg_data;
            if (accept && (req.operation == srr_pkg::OP_PUSH))
            begin
                phase_reg  <= phase_next;
                prev_l_reg <= req.left_sample;
                prev_r_reg <= req.right_sample;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/srr_queue.sv
// ----------------------------------------------------------------------------
// srr_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_queue #(
    parameter int DEPTH = srr_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire srr_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output srr_pkg::cmd_t      out_cmd
);

    localparam int QP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QC_W = $clog2(DEPTH + 1);

    srr_pkg::cmd_t   q_mem_reg [DEPTH];
    logic [QP_W-1:0] head_reg, tail_reg;
    logic [QC_W-1:0] count_reg;
    logic            do_push, do_pop;

    assign in_ready  = (count_reg != QC_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = q_mem_reg[head_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem_reg[tail_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                tail_reg <= (tail_reg == QP_W'(DEPTH - 1)) ? '0 : tail_reg + QP_W'(1);
            if (do_pop)
                head_reg <= (head_reg == QP_W'(DEPTH - 1)) ? '0 : head_reg + QP_W'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QC_W'(1);
                2'b01:   count_reg <= count_reg - QC_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back
// Output ring FIFO: stores frames, serves pops through a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_back #(
    parameter int RING_FRAMES = srr_pkg::RING_FRAMES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire srr_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output srr_pkg::rsp_t      rsp
);

    localparam int PTR_W = $clog2(RING_FRAMES);
    localparam int CNT_W = $clog2(RING_FRAMES + 1);

    logic [31:0]      ring_mem [RING_FRAMES];
    logic [31:0]      rd_data_reg;
    logic             underrun_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             rsp_vld_reg;
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] count_reg;
    logic             take, wr_en, rd_en, pop_take, empty;

    assign empty     = (count_reg == '0);
    assign cmd_ready = !cmd.is_pop || !rsp_vld_reg || rsp_ready;
    assign take      = cmd_valid && cmd_ready;
    assign pop_take  = take && cmd.is_pop;
    assign wr_en     = take && !cmd.is_pop && (count_reg != CNT_W'(RING_FRAMES));
    assign rd_en     = pop_take && !empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wp_reg] <= {cmd.right, cmd.left};
        if (rd_en)
            rd_data_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop_take)
        begin
            underrun_reg <= empty;
            fill_reg     <= empty ? '0 : count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            count_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg    <= (wp_reg == PTR_W'(RING_FRAMES - 1)) ? '0 : wp_reg + PTR_W'(1);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (rd_en)
            begin
                rp_reg    <= (rp_reg == PTR_W'(RING_FRAMES - 1)) ? '0 : rp_reg + PTR_W'(1);
                count_reg <= count_reg - CNT_W'(1);
            end
            if (pop_take)
                rsp_vld_reg <= 1'b1;
            else if (rsp_ready)
                rsp_vld_reg <= 1'b0;
        end
    end

    assign rsp_valid       = rsp_vld_reg;
    assign rsp.left_out    = underrun_reg ? '0 : rd_data_reg[15:0];
    assign rsp.right_out   = underrun_reg ? '0 : rd_data_reg[31:16];
    assign rsp.underrun    = underrun_reg;
    assign rsp.fill_frames = srr_pkg::FILL_W'(fill_reg);

endmodule

`default_nettype wire

>>> design/stereo_linear_resampler_ring_top.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_ring_top
// Stereo linear-interpolation resampler feeding an output ring FIFO.
//
//   channel   signals                         carries
//   req       req_valid / req_ready / req     push frame or pop request
//   rsp       rsp_valid / rsp_ready / rsp     popped frame, underrun, fill
//   cfg       cfg_valid / cfg_ready / cfg_data phase step, q6
//
// One item per cycle sustained; the front takes an item every cycle the
// command queue has room. A pop answer passes through the queue stage, then
// the registered ring read, before it appears.
// A stalled response blocks only a pop at the queue head; a store at the
// head still drains.
// Asynchronous reset clears phase, previous frame, pointers and counts;
// ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler_ring_top #(
    parameter int RING_FRAMES   = srr_pkg::RING_FRAMES_DEF,
    parameter int FRACTION_BITS = srr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [srr_pkg::STEP_W-1:0]  cfg_data,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire srr_pkg::req_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output srr_pkg::rsp_t                    rsp
);

    logic          enq_valid, enq_ready;
    srr_pkg::cmd_t enq_cmd;
    logic          deq_valid, deq_ready;
    srr_pkg::cmd_t deq_cmd;

    srr_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_cmd   (enq_cmd)
    );

    srr_queue #(
        .DEPTH(srr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (enq_valid),
        .in_ready  (enq_ready),
        .in_cmd    (enq_cmd),
        .out_valid (deq_valid),
        .out_ready (deq_ready),
        .out_cmd   (deq_cmd)
    );

    srr_back #(
        .RING_FRAMES(RING_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (deq_valid),
        .cmd_ready (deq_ready),
        .cmd       (deq_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> design/srr_checker.sv
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks on the resampler top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire srr_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire srr_pkg::rsp_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("req item changed or dropped while waiting");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp_valid dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("rsp payload changed while stalled");

    a_underrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.underrun |->
            (rsp.left_out == '0) && (rsp.right_out == '0) && (rsp.fill_frames == '0))
        else $error("underrun item carries nonzero fields");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("rsp_valid high during reset");

endmodule

bind stereo_linear_resampler_ring_top srr_checker u_srr_checker (.*);

`default_nettype wire
